/* src/gcd_pkg.sv */
// shared types, constants and the arctangent table of the great-circle distance block
`default_nettype none
package gcd_pkg;

	// width of every cordic datapath value (q30 with headroom)
	localparam int CW = 34;
	typedef logic signed [CW-1:0] cval_t;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int STEPS_MAX = 32;

	// pipeline depths of the fixed units
	localparam int TO_RAD_LAT = 4;
	localparam int ISQRT_LAT = 31;

	localparam int ANG_W = 32;
	localparam int RADIUS_W = 22;
	localparam int DIST_W = 24;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 22'd1631436;

	localparam cval_t K_Q30 = 34'sd652032874;
	localparam cval_t ONE_Q30 = 34'sd1073741824;
	localparam logic signed [CW:0] PI_Q30 = 35'sd3373259426;

	localparam logic signed [23:0] LAT_MAX = 24'sd5898240;
	localparam logic signed [24:0] LON_MAX = 25'sd11796480;
	localparam logic [24:0] DEG180 = 25'd11796480;
	localparam logic [24:0] DEG360 = 25'd23592960;
	localparam logic [24:0] DEG90 = 25'd5898240;

	// degrees to radians: q30 = (deg*RAD_MUL + (deg*RAD_REM + RAD_BIAS)/180) >> 16
	localparam logic [24:0] RAD_MUL = 25'd18740330;
	localparam logic [28:0] RAD_REM = 29'd26;
	localparam logic [28:0] RAD_BIAS = 29'd5898240;
	localparam logic [29:0] RAD_RECIP = 30'd763549741;
	localparam int RAD_SHIFT = 37;
	localparam logic [28:0] RAD_DIV = 29'd180;

	// truncated q30 arctangent of 2^-i
	function automatic cval_t atan_q30(input int unsigned i);
		case (i)
			0: return 34'sd843314856;
			1: return 34'sd497837829;
			2: return 34'sd263043836;
			3: return 34'sd133525158;
			4: return 34'sd67021686;
			5: return 34'sd33543515;
			6: return 34'sd16775850;
			7: return 34'sd8388437;
			8: return 34'sd4194282;
			9: return 34'sd2097149;
			10: return 34'sd1048575;
			11: return 34'sd524287;
			12: return 34'sd262143;
			13: return 34'sd131071;
			14: return 34'sd65535;
			15: return 34'sd32767;
			16: return 34'sd16383;
			17: return 34'sd8191;
			18: return 34'sd4095;
			19: return 34'sd2047;
			20: return 34'sd1023;
			21: return 34'sd511;
			22: return 34'sd255;
			23: return 34'sd127;
			24: return 34'sd63;
			25: return 34'sd31;
			26: return 34'sd15;
			27: return 34'sd7;
			28: return 34'sd3;
			29: return 34'sd1;
			default: return '0;
		endcase
	endfunction

endpackage
`default_nettype wire

/* src/gcd_delay.sv */
// fixed-depth shift line for side data that travels beside the datapath
`default_nettype none
module gcd_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] din,
	output logic      [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_q [0:DEPTH-1];

	// shift on every advance
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
		end
	end

	for (genvar k = 1; k < DEPTH; k++) begin : g_tap
		always_ff @(posedge clk) begin
			if (en) begin
				tap_q[k] <= tap_q[k-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule
`default_nettype wire

/* src/gcd_to_rad.sv */
// pipelined conversion of a degree magnitude (q16) to radians (q30), rounded half up
`default_nettype none
module gcd_to_rad import gcd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [23:0]      deg,
	output logic      [ANG_W-1:0] rad
);

	logic [47:0] a_s1, a_s2, a_s3;
	logic [28:0] b_s1, b_s2;
	logic [58:0] bm_s2;
	logic [21:0] bq_s3;
	logic [21:0] q0;
	logic [28:0] r;

	// main product and the remainder term to be divided by 180
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= 48'(deg) * 48'(RAD_MUL);
			b_s1 <= 29'(deg) * RAD_REM + RAD_BIAS;
		end
	end

	// reciprocal multiply
	always_ff @(posedge clk) begin
		if (en) begin
			bm_s2 <= 59'(b_s1) * 59'(RAD_RECIP);
			a_s2 <= a_s1;
			b_s2 <= b_s1;
		end
	end

	// quotient estimate is low by at most one
	always_comb begin
		q0 = 22'(bm_s2 >> RAD_SHIFT);
		r = b_s2 - 29'(q0) * RAD_DIV;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bq_s3 <= (r >= RAD_DIV) ? q0 + 22'd1 : q0;
			a_s3 <= a_s2;
		end
	end

	// final sum and scale
	always_ff @(posedge clk) begin
		if (en) begin
			rad <= ANG_W'((a_s3 + 48'(bq_s3)) >> 16);
		end
	end

endmodule
`default_nettype wire

/* src/gcd_cordic_cell.sv */
// one cordic micro-rotation with its output register
`default_nettype none
module gcd_cordic_cell import gcd_pkg::*; #(
	parameter int STEP = 0,
	parameter bit VECT = 1'b0
) (
	input  wire logic  clk,
	input  wire logic  en,
	input  wire cval_t x_i,
	input  wire cval_t y_i,
	input  wire cval_t z_i,
	output cval_t      x_o,
	output cval_t      y_o,
	output cval_t      z_o
);

	cval_t xs, ys;
	logic pos, sub;

	// rotation steers on the angle, vectoring on y
	always_comb begin
		xs = x_i >>> STEP;
		ys = y_i >>> STEP;
		pos = VECT ? !y_i[CW-1] : !z_i[CW-1];
		sub = VECT ? pos : !pos;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sub) begin
				x_o <= x_i + ys;
				y_o <= y_i - xs;
				z_o <= z_i + atan_q30(STEP);
			end else begin
				x_o <= x_i - ys;
				y_o <= y_i + xs;
				z_o <= z_i - atan_q30(STEP);
			end
		end
	end

endmodule
`default_nettype wire

/* src/gcd_cordic.sv */
// row of cordic cells, one iteration per cell
`default_nettype none
module gcd_cordic import gcd_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF,
	parameter bit VECT = 1'b0
) (
	input  wire logic  clk,
	input  wire logic  en,
	input  wire cval_t x_i,
	input  wire cval_t y_i,
	input  wire cval_t z_i,
	output cval_t      x_o,
	output cval_t      y_o,
	output cval_t      z_o
);

	cval_t xc [0:STEPS];
	cval_t yc [0:STEPS];
	cval_t zc [0:STEPS];

	assign xc[0] = x_i;
	assign yc[0] = y_i;
	assign zc[0] = z_i;

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		gcd_cordic_cell #(
			.STEP(i),
			.VECT(VECT)
		) u_cell (
			.clk(clk),
			.en(en),
			.x_i(xc[i]),
			.y_i(yc[i]),
			.z_i(zc[i]),
			.x_o(xc[i+1]),
			.y_o(yc[i+1]),
			.z_o(zc[i+1])
		);
	end

	assign x_o = xc[STEPS];
	assign y_o = yc[STEPS];
	assign z_o = zc[STEPS];

endmodule
`default_nettype wire

/* src/gcd_isqrt.sv */
// pipelined integer square root, one result bit per stage
`default_nettype none
module gcd_isqrt import gcd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [60:0] op,
	output logic      [30:0] root
);

	logic [61:0] op_q [1:ISQRT_LAT];
	logic [61:0] res_q [1:ISQRT_LAT];
	wire  [61:0] op_in [0:ISQRT_LAT-1];
	wire  [61:0] res_in [0:ISQRT_LAT-1];

	assign op_in[0] = 62'(op);
	assign res_in[0] = '0;

	for (genvar k = 1; k < ISQRT_LAT; k++) begin : g_link
		assign op_in[k] = op_q[k];
		assign res_in[k] = res_q[k];
	end

	// restoring step with the trial bit at 4^(30-k)
	for (genvar k = 0; k < ISQRT_LAT; k++) begin : g_stage
		localparam logic [61:0] ONE = 62'(1) << (2 * (ISQRT_LAT - 1 - k));
		always_ff @(posedge clk) begin
			if (en) begin
				if (op_in[k] >= res_in[k] + ONE) begin
					op_q[k+1] <= op_in[k] - (res_in[k] + ONE);
					res_q[k+1] <= (res_in[k] >> 1) + ONE;
				end else begin
					op_q[k+1] <= op_in[k];
					res_q[k+1] <= res_in[k] >> 1;
				end
			end
		end
	end

	assign root = res_q[ISQRT_LAT][30:0];

endmodule
`default_nettype wire

/* src/great_circle_distance.sv */
// Great-circle distance between two points by the spherical law of cosines. Fully pipelined:
// one item per cycle while no result is stalled; each item's distance passes through the three
// parallel sine/cosine cordic rows, the 31-stage square root and the vectoring cordic row that
// forms the arccosine. The whole pipeline advances together and holds while a result is
// stalled; item_stall is high exactly then. The radius register is written with radius_we and
// takes effect for items that reach the final multiply after the write.
`default_nettype none
module great_circle_distance import gcd_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 radius_we,
	input  wire logic [RADIUS_W-1:0]  radius_wdata,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic signed [23:0]   lat_a,
	input  wire logic signed [24:0]   lon_a,
	input  wire logic signed [23:0]   lat_b,
	input  wire logic signed [24:0]   lon_b,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [DIST_W-1:0]         distance
);

	localparam int LAT = 45 + 2 * CORDIC_STEPS;

	logic en;
	logic [LAT-1:0] vld_q;
	logic [RADIUS_W-1:0] radius_q;

	// global advance
	assign en = !(result_valid && result_stall);
	assign item_stall = !en;
	assign result_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], item_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (radius_we) begin
			radius_q <= radius_wdata;
		end
	end

	// front: saturate, magnitudes, fold longitude difference into 0..90 degrees
	logic signed [23:0] la, lb;
	logic signed [24:0] loa, lob;
	logic signed [25:0] dl;
	logic [24:0] d0, d1, d2;
	logic negd;
	logic [23:0] mla_s1, mlb_s1, d_s1;
	logic nla_s1, nlb_s1, negd_s1;

	always_comb begin
		la = (lat_a > LAT_MAX) ? LAT_MAX : (lat_a < -LAT_MAX) ? -LAT_MAX : lat_a;
		lb = (lat_b > LAT_MAX) ? LAT_MAX : (lat_b < -LAT_MAX) ? -LAT_MAX : lat_b;
		loa = (lon_a > LON_MAX) ? LON_MAX : (lon_a < -LON_MAX) ? -LON_MAX : lon_a;
		lob = (lon_b > LON_MAX) ? LON_MAX : (lon_b < -LON_MAX) ? -LON_MAX : lon_b;
		dl = 26'(loa) - 26'(lob);
		d0 = dl[25] ? 25'(-dl) : 25'(dl);
		d1 = (d0 > DEG180) ? DEG360 - d0 : d0;
		negd = d1 > DEG90;
		d2 = negd ? DEG180 - d1 : d1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mla_s1 <= la[23] ? 24'(-la) : 24'(la);
			mlb_s1 <= lb[23] ? 24'(-lb) : 24'(lb);
			nla_s1 <= la[23];
			nlb_s1 <= lb[23];
			d_s1 <= d2[23:0];
			negd_s1 <= negd;
		end
	end

	// radians
	logic [ANG_W-1:0] rla, rlb, rd;

	gcd_to_rad u_rad_a (.clk(clk), .en(en), .deg(mla_s1), .rad(rla));
	gcd_to_rad u_rad_b (.clk(clk), .en(en), .deg(mlb_s1), .rad(rlb));
	gcd_to_rad u_rad_d (.clk(clk), .en(en), .deg(d_s1), .rad(rd));

	// sine and cosine rows
	cval_t ca, sa, cb, sb, cd;

	gcd_cordic #(.STEPS(CORDIC_STEPS), .VECT(1'b0)) u_rot_a (
		.clk(clk), .en(en), .x_i(K_Q30), .y_i('0), .z_i(CW'(rla)),
		.x_o(ca), .y_o(sa), .z_o()
	);
	gcd_cordic #(.STEPS(CORDIC_STEPS), .VECT(1'b0)) u_rot_b (
		.clk(clk), .en(en), .x_i(K_Q30), .y_i('0), .z_i(CW'(rlb)),
		.x_o(cb), .y_o(sb), .z_o()
	);
	gcd_cordic #(.STEPS(CORDIC_STEPS), .VECT(1'b0)) u_rot_d (
		.clk(clk), .en(en), .x_i(K_Q30), .y_i('0), .z_i(CW'(rd)),
		.x_o(cd), .y_o(), .z_o()
	);

	logic [2:0] flags_d;

	gcd_delay #(.WIDTH(3), .DEPTH(TO_RAD_LAT + CORDIC_STEPS)) u_dly_flags (
		.clk(clk), .en(en), .din({nla_s1, nlb_s1, negd_s1}), .dout(flags_d)
	);

	// law of cosines argument
	cval_t sa_v, sb_v, cd_v;
	logic signed [2*CW-1:0] pss_s2, pcc_s2, pc_s4;
	cval_t cd_s2, ss_s3, cc_s3, cd_s3, ss_s4;

	always_comb begin
		sa_v = flags_d[2] ? -sa : sa;
		sb_v = flags_d[1] ? -sb : sb;
		cd_v = flags_d[0] ? -cd : cd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pss_s2 <= sa_v * sb_v;
			pcc_s2 <= ca * cb;
			cd_s2 <= cd_v;
			ss_s3 <= cval_t'(pss_s2 >>> 30);
			cc_s3 <= cval_t'(pcc_s2 >>> 30);
			cd_s3 <= cd_s2;
			pc_s4 <= cc_s3 * cd_s3;
			ss_s4 <= ss_s3;
		end
	end

	// clamp to +-1, split sign and magnitude
	logic signed [CW:0] arg, argc;
	logic [30:0] ax_s5, ax_s6, ax_s7;
	logic nega_s5, nega_s6, nega_s7;
	logic [61:0] sq_s6;
	logic [60:0] rem_s7;

	always_comb begin
		arg = (CW+1)'(ss_s4) + (CW+1)'(pc_s4 >>> 30);
		argc = (arg > (CW+1)'(ONE_Q30)) ? (CW+1)'(ONE_Q30) :
			(arg < -(CW+1)'(ONE_Q30)) ? -(CW+1)'(ONE_Q30) : arg;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s5 <= argc[CW] ? 31'(-argc) : 31'(argc);
			nega_s5 <= argc[CW];
			sq_s6 <= 62'(ax_s5) * 62'(ax_s5);
			ax_s6 <= ax_s5;
			nega_s6 <= nega_s5;
			rem_s7 <= 61'((62'(1) << 60) - sq_s6);
			ax_s7 <= ax_s6;
			nega_s7 <= nega_s6;
		end
	end

	// sqrt(1 - x*x)
	logic [30:0] yv, ax_d;
	logic nega_d;

	gcd_isqrt u_sqrt (.clk(clk), .en(en), .op(rem_s7), .root(yv));

	gcd_delay #(.WIDTH(31), .DEPTH(ISQRT_LAT)) u_dly_ax (
		.clk(clk), .en(en), .din(ax_s7), .dout(ax_d)
	);
	gcd_delay #(.WIDTH(1), .DEPTH(ISQRT_LAT + CORDIC_STEPS)) u_dly_neg (
		.clk(clk), .en(en), .din(nega_s7), .dout(nega_d)
	);

	// arccosine as atan2(sqrt(1 - x*x), x)
	cval_t ang;

	gcd_cordic #(.STEPS(CORDIC_STEPS), .VECT(1'b1)) u_vec (
		.clk(clk), .en(en), .x_i(CW'(ax_d)), .y_i(CW'(yv)), .z_i('0),
		.x_o(), .y_o(), .z_o(ang)
	);

	// angle fix-up for negative arguments, then scale by radius
	logic signed [CW:0] a0, a1;
	logic [ANG_W-1:0] ang_s8;
	logic [53:0] prod_s9;
	logic [54:0] rnd;

	always_comb begin
		a0 = ang[CW-1] ? '0 : (CW+1)'(ang);
		a1 = nega_d ? PI_Q30 - a0 : a0;
		rnd = 55'(prod_s9) + (55'(1) << 29);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s8 <= a1[CW] ? '0 : ANG_W'(a1);
			prod_s9 <= 54'(radius_q) * 54'(ang_s8);
			distance <= ((rnd >> 30) > 55'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(rnd >> 30);
		end
	end

endmodule
`default_nettype wire

/* src/gcd_checker.sv */
// port-level assertions for the great-circle distance block, bound to the top level
`default_nettype none
module gcd_checker import gcd_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 radius_we,
	input wire logic [RADIUS_W-1:0]  radius_wdata,
	input wire logic                 item_valid,
	input wire logic                 item_stall,
	input wire logic signed [23:0]   lat_a,
	input wire logic signed [24:0]   lon_a,
	input wire logic signed [23:0]   lat_b,
	input wire logic signed [24:0]   lon_b,
	input wire logic                 result_valid,
	input wire logic                 result_stall,
	input wire logic [DIST_W-1:0]    distance
);

	// a held result stays and keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(distance))
		else $error("held result changed");

	// distance never exceeds 13176832, just above pi times the largest radius
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> distance <= 24'd13176832)
		else $error("distance out of range");

	// with no result waiting the block takes items
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("stall without a waiting result");

	// a result leaving frees the input in the same cycle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall |-> !item_stall)
		else $error("stall while result drains");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);
`default_nettype wire
